@@ design/wpmc_pkg.sv @@
`timescale 1ns / 1ps
package wpmc_pkg;

   // Field widths
   localparam int POSE_W = 24;
   localparam int COV_W  = 48;
   localparam int STAT_W = 2;

   // Default sample store depth
   localparam int DEF_MAX_SAMPLES = 512;

   // Bits of the multiplier operand consumed per cycle
   localparam int MUL_DIGIT_W = 8;

   // Saturation limits of the covariance fields
   localparam logic [COV_W-1:0] COV_MAX_U = {COV_W{1'b1}};
   localparam logic [COV_W-1:0] COV_MAX_P = {1'b0, {(COV_W-1){1'b1}}};
   localparam logic [COV_W-1:0] COV_MAX_N = {1'b1, {(COV_W-1){1'b0}}};

   // Status codes
   localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_ZERO_W   = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_SINGLE   = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd3;

   typedef struct packed {
      logic signed [POSE_W-1:0] pose_x;
      logic signed [POSE_W-1:0] pose_y;
      logic signed [POSE_W-1:0] pose_heading;
      logic [POSE_W-1:0]        sample_weight;
      logic                     last_sample;
   } req_type;

   typedef struct packed {
      logic signed [POSE_W-1:0] mean_x;
      logic signed [POSE_W-1:0] mean_y;
      logic signed [POSE_W-1:0] mean_heading;
      logic [COV_W-1:0]         cov_xx;
      logic signed [COV_W-1:0]  cov_xy;
      logic [COV_W-1:0]         cov_yy;
      logic [COV_W-1:0]         cov_hh;
      logic [STAT_W-1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic signed [POSE_W-1:0] pose_x;
      logic signed [POSE_W-1:0] pose_y;
      logic signed [POSE_W-1:0] pose_heading;
      logic [POSE_W-1:0]        sample_weight;
   } sample_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_START,
      ST_READ,
      ST_LATCH,
      ST_MUL,
      ST_MUL_WAIT,
      ST_DIV,
      ST_DIV_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_SUM,
      PH_DEV,
      PH_DEN
   } phase_type;

endpackage

@@ design/wpmc_store.sv @@
`timescale 1ns / 1ps
module wpmc_store import wpmc_pkg::*; #(
   parameter int DEPTH  = DEF_MAX_SAMPLES,
   parameter int ADDR_W = $clog2(DEF_MAX_SAMPLES)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  sample_type        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output sample_type        rd_data
);

   sample_type mem_ff [DEPTH];
   sample_type rd_data_ff;

   // Write one sample, read one sample with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/wpmc_mul.sv @@
`timescale 1ns / 1ps
module wpmc_mul import wpmc_pkg::*; #(
   parameter int A_W = 82,
   parameter int B_W = 34
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic               done,
   output logic [A_W+B_W-1:0] p
);

   localparam int P_W   = A_W + B_W;
   localparam int NDIG  = (B_W + MUL_DIGIT_W - 1) / MUL_DIGIT_W;
   localparam int BP_W  = NDIG * MUL_DIGIT_W;
   localparam int CNT_W = $clog2(NDIG + 1);

   logic [P_W-1:0]   a_ff, a_in;
   logic [BP_W-1:0]  b_ff, b_in;
   logic [P_W-1:0]   p_ff, p_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [P_W-1:0]   partial;

   // Add one digit of b times the shifted a per cycle, low digit first
   always_comb begin
      partial = a_ff * P_W'(b_ff[MUL_DIGIT_W-1:0]);
      a_in    = a_ff;
      b_in    = b_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = P_W'(a);
         b_in    = BP_W'(b);
         p_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         p_in   = p_ff + partial;
         a_in   = a_ff << MUL_DIGIT_W;
         b_in   = b_ff >> MUL_DIGIT_W;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NDIG - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      p_ff   <= p_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign p    = p_ff;

endmodule

@@ design/wpmc_div.sv @@
`timescale 1ns / 1ps
module wpmc_div import wpmc_pkg::*; #(
   parameter int N_W = 118,
   parameter int D_W = 69
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] num,
   input  logic [D_W-1:0] den,
   output logic           done,
   output logic [N_W-1:0] quo
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic [N_W-1:0]   q_ff, q_in;
   logic [D_W-1:0]   rem_ff, rem_in;
   logic [D_W-1:0]   den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D_W:0]     rem_sh;
   logic [D_W:0]     rem_sub;
   logic             fits;

   // Restoring division, one quotient bit per cycle, high bit first
   always_comb begin
      rem_sh  = {rem_ff, q_ff[N_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      fits    = rem_sh >= {1'b0, den_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
         q_in   = {q_ff[N_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

@@ design/weighted_pose_mean_covariance_core.sv @@
`timescale 1ns / 1ps
// Weighted pose mean and covariance.
// req_*: one pose sample per transaction (x, y, heading, weight, last flag).
// While loading, req_ready stays high and a sample is taken every cycle.
// Samples past MAX_SAMPLES are dropped and the result reports overflow.
// The transaction flagged last closes the set; req_ready then drops while
// the set is processed, and one result transaction appears on rsp_*.
// Processing reuses one digit-serial multiplier (8 bits of operand per
// cycle, NDIG = ceil((24 + CW) / 8) steps, CW = clog2(MAX_SAMPLES + 1))
// and one bit-serial divider (DN = 2*CW + 98 steps). The result holds on
// rsp_* until rsp_ready; a new set is accepted only after that. Reset
// empties the sample set and returns to loading; the sample store itself
// needs no clearing.
module weighted_pose_mean_covariance_core import wpmc_pkg::*; #(
   parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CW     = $clog2(MAX_SAMPLES + 1);
   localparam int SW     = $clog2(MAX_SAMPLES);
   localparam int WS_W   = POSE_W + CW;
   localparam int S2_W   = 2 * POSE_W + CW;
   localparam int SUM_W  = 2 * POSE_W + CW;
   localparam int MA_W   = 3 * POSE_W + CW;
   localparam int ACC_W  = MA_W + 1;
   localparam int MB_W   = POSE_W + CW;
   localparam int MP_W   = MA_W + MB_W;
   localparam int PR_W   = 2 * POSE_W;
   localparam int DEN_W  = 2 * POSE_W + 2 * CW;
   localparam int DN_W   = MP_W + 2;
   localparam int DD_W   = DEN_W + 1;
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SAMPLES);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [2:0]  op_ff, op_in;
   logic [2:0]  dop_ff, dop_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          ovf_ff, ovf_in;
   logic [1:0]    nz_ff, nz_in;
   logic [WS_W-1:0] wsum_ff, wsum_in;
   logic [S2_W-1:0] s2_ff, s2_in;
   logic signed [SUM_W-1:0] sumx_ff, sumx_in, sumy_ff, sumy_in, sumh_ff, sumh_in;
   logic signed [ACC_W-1:0] axx_ff, axx_in, axy_ff, axy_in;
   logic signed [ACC_W-1:0] ayy_ff, ayy_in, ahh_ff, ahh_in;
   logic [PR_W-1:0]  prod_ff, prod_in;
   logic             sgn_ff, sgn_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [MP_W-1:0]  nxx_ff, nxx_in, nxy_ff, nxy_in, nyy_ff, nyy_in, nhh_ff, nhh_in;
   rsp_type          res_ff, res_in;

   // Store and shared units
   logic       mem_wr, mem_rd;
   sample_type mem_wdata, smp;
   logic            mul_start, mul_done;
   logic [MA_W-1:0] mul_a;
   logic [MB_W-1:0] mul_b;
   logic [MP_W-1:0] mul_p;
   logic            div_start, div_done;
   logic [DN_W-1:0] div_num;
   logic [DD_W-1:0] div_den;
   logic [DN_W-1:0] div_q;

   // Sample-derived values
   logic              x_neg, y_neg, h_neg;
   logic [POSE_W-1:0] x_mag, y_mag, h_mag;
   logic signed [POSE_W:0] dx, dy, dh;
   logic [POSE_W-1:0] dx_mag, dy_mag, dh_mag;
   logic [SUM_W-1:0]  sx_mag, sy_mag, sh_mag;
   logic [MA_W-1:0]   axy_mag;
   logic              div_neg;
   logic [DN_W-1:0]   mean_sum_mag;
   logic [POSE_W-1:0] mean_val;
   logic [COV_W-1:0]  cov_u, cov_s_mag;
   logic [DN_W-1:0]   lim_s;

   assign mem_wdata = '{pose_x: req_data.pose_x, pose_y: req_data.pose_y,
                        pose_heading: req_data.pose_heading,
                        sample_weight: req_data.sample_weight};

   wpmc_store #(.DEPTH(MAX_SAMPLES), .ADDR_W(SW)) u_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (cnt_ff[SW-1:0]),
      .wr_data (mem_wdata),
      .rd_en   (mem_rd),
      .rd_addr (idx_ff[SW-1:0]),
      .rd_data (smp)
   );

   wpmc_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   wpmc_div #(.N_W(DN_W), .D_W(DD_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_q)
   );

   // Magnitudes and deviations of the sample under work
   always_comb begin
      x_neg  = smp.pose_x[POSE_W-1];
      y_neg  = smp.pose_y[POSE_W-1];
      h_neg  = smp.pose_heading[POSE_W-1];
      x_mag  = x_neg ? POSE_W'(-smp.pose_x) : smp.pose_x;
      y_mag  = y_neg ? POSE_W'(-smp.pose_y) : smp.pose_y;
      h_mag  = h_neg ? POSE_W'(-smp.pose_heading) : smp.pose_heading;
      dx     = (POSE_W+1)'(smp.pose_x) - (POSE_W+1)'(res_ff.mean_x);
      dy     = (POSE_W+1)'(smp.pose_y) - (POSE_W+1)'(res_ff.mean_y);
      dh     = (POSE_W+1)'(smp.pose_heading) - (POSE_W+1)'(res_ff.mean_heading);
      dx_mag = dx[POSE_W] ? POSE_W'(-dx) : dx[POSE_W-1:0];
      dy_mag = dy[POSE_W] ? POSE_W'(-dy) : dy[POSE_W-1:0];
      dh_mag = dh[POSE_W] ? POSE_W'(-dh) : dh[POSE_W-1:0];
      sx_mag = sumx_ff[SUM_W-1] ? SUM_W'(-sumx_ff) : SUM_W'(sumx_ff);
      sy_mag = sumy_ff[SUM_W-1] ? SUM_W'(-sumy_ff) : SUM_W'(sumy_ff);
      sh_mag = sumh_ff[SUM_W-1] ? SUM_W'(-sumh_ff) : SUM_W'(sumh_ff);
      axy_mag = axy_ff[ACC_W-1] ? MA_W'(-axy_ff) : MA_W'(axy_ff);
   end

   // Select multiplier operands for the current step
   always_comb begin
      mul_a = '0;
      mul_b = MB_W'(smp.sample_weight);
      case (phase_ff)
         PH_SUM: begin
            case (op_ff)
               3'd0:    mul_a = MA_W'(smp.sample_weight);
               3'd1:    mul_a = MA_W'(x_mag);
               3'd2:    mul_a = MA_W'(y_mag);
               default: mul_a = MA_W'(h_mag);
            endcase
         end
         PH_DEV: begin
            case (op_ff)
               3'd0: begin
                  mul_a = MA_W'(dx_mag);
                  mul_b = MB_W'(dx_mag);
               end
               3'd2: begin
                  mul_a = MA_W'(dx_mag);
                  mul_b = MB_W'(dy_mag);
               end
               3'd4: begin
                  mul_a = MA_W'(dy_mag);
                  mul_b = MB_W'(dy_mag);
               end
               3'd6: begin
                  mul_a = MA_W'(dh_mag);
                  mul_b = MB_W'(dh_mag);
               end
               default: mul_a = MA_W'(prod_ff);
            endcase
         end
         default: begin
            mul_b = MB_W'(wsum_ff);
            case (op_ff)
               3'd0:    mul_a = MA_W'(wsum_ff);
               3'd1:    mul_a = MA_W'(axx_ff);
               3'd2:    mul_a = axy_mag;
               3'd3:    mul_a = MA_W'(ayy_ff);
               default: mul_a = MA_W'(ahh_ff);
            endcase
         end
      endcase
   end

   // Select divider operands and shape its quotient
   always_comb begin
      case (dop_ff)
         3'd0: begin
            mean_sum_mag = DN_W'(sx_mag);
            div_neg      = sumx_ff[SUM_W-1];
         end
         3'd1: begin
            mean_sum_mag = DN_W'(sy_mag);
            div_neg      = sumy_ff[SUM_W-1];
         end
         default: begin
            mean_sum_mag = DN_W'(sh_mag);
            div_neg      = sumh_ff[SUM_W-1];
         end
      endcase
      if (dop_ff <= 3'd2) begin
         div_num = (mean_sum_mag << 1) + DN_W'(wsum_ff);
         div_den = DD_W'({wsum_ff, 1'b0});
      end else begin
         case (dop_ff)
            3'd3:    div_num = DN_W'({nxx_ff, 1'b0});
            3'd4:    div_num = DN_W'({nxy_ff, 1'b0});
            3'd5:    div_num = DN_W'({nyy_ff, 1'b0});
            default: div_num = DN_W'({nhh_ff, 1'b0});
         endcase
         div_num = div_num + DN_W'(den_ff);
         div_den = {den_ff, 1'b0};
      end
      mean_val  = div_neg ? POSE_W'(-div_q[POSE_W-1:0]) : div_q[POSE_W-1:0];
      cov_u     = (div_q > DN_W'(COV_MAX_U)) ? COV_MAX_U : div_q[COV_W-1:0];
      lim_s     = axy_ff[ACC_W-1] ? DN_W'(COV_MAX_N) : DN_W'(COV_MAX_P);
      cov_s_mag = (div_q > lim_s) ? lim_s[COV_W-1:0] : div_q[COV_W-1:0];
   end

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      op_in     = op_ff;
      dop_in    = dop_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      ovf_in    = ovf_ff;
      nz_in     = nz_ff;
      wsum_in   = wsum_ff;
      s2_in     = s2_ff;
      sumx_in   = sumx_ff;
      sumy_in   = sumy_ff;
      sumh_in   = sumh_ff;
      axx_in    = axx_ff;
      axy_in    = axy_ff;
      ayy_in    = ayy_ff;
      ahh_in    = ahh_ff;
      prod_in   = prod_ff;
      sgn_in    = sgn_ff;
      den_in    = den_ff;
      nxx_in    = nxx_ff;
      nxy_in    = nxy_ff;
      nyy_in    = nyy_ff;
      nhh_in    = nhh_ff;
      res_in    = res_ff;
      mem_wr    = 1'b0;
      mem_rd    = 1'b0;
      mul_start = 1'b0;
      div_start = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         // Take samples, drop those past capacity
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (cnt_ff != CNT_MAX) begin
                  mem_wr = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_sample) begin
                  state_in = ST_START;
               end
            end
         end
         // Clear the per-set sums and results
         ST_START: begin
            wsum_in  = '0;
            s2_in    = '0;
            sumx_in  = '0;
            sumy_in  = '0;
            sumh_in  = '0;
            axx_in   = '0;
            axy_in   = '0;
            ayy_in   = '0;
            ahh_in   = '0;
            nz_in    = '0;
            res_in   = '0;
            idx_in   = '0;
            phase_in = PH_SUM;
            state_in = (cnt_ff == '0) ? ST_OUT : ST_READ;
         end
         ST_READ: begin
            mem_rd   = 1'b1;
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            if (phase_ff == PH_SUM) begin
               wsum_in = wsum_ff + WS_W'(smp.sample_weight);
            end else if (smp.sample_weight != '0 && nz_ff != 2'd2) begin
               nz_in = nz_ff + 2'd1;
            end
            op_in    = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            mul_start = 1'b1;
            state_in  = ST_MUL_WAIT;
         end
         // Fold the product into its target, then advance
         ST_MUL_WAIT: begin
            if (mul_done) begin
               case (phase_ff)
                  PH_SUM: begin
                     case (op_ff)
                        3'd0: s2_in = s2_ff + S2_W'(mul_p);
                        3'd1: sumx_in = x_neg ? sumx_ff - SUM_W'(mul_p)
                                              : sumx_ff + SUM_W'(mul_p);
                        3'd2: sumy_in = y_neg ? sumy_ff - SUM_W'(mul_p)
                                              : sumy_ff + SUM_W'(mul_p);
                        default: sumh_in = h_neg ? sumh_ff - SUM_W'(mul_p)
                                                 : sumh_ff + SUM_W'(mul_p);
                     endcase
                  end
                  PH_DEV: begin
                     case (op_ff)
                        3'd1: axx_in = axx_ff + ACC_W'(mul_p);
                        3'd3: axy_in = sgn_ff ? axy_ff - ACC_W'(mul_p)
                                              : axy_ff + ACC_W'(mul_p);
                        3'd5: ayy_in = ayy_ff + ACC_W'(mul_p);
                        3'd7: ahh_in = ahh_ff + ACC_W'(mul_p);
                        default: begin
                           prod_in = mul_p[PR_W-1:0];
                           sgn_in  = (op_ff == 3'd2) && (dx[POSE_W] ^ dy[POSE_W]);
                        end
                     endcase
                  end
                  default: begin
                     case (op_ff)
                        3'd0: den_in = DEN_W'(mul_p) - DEN_W'(s2_ff);
                        3'd1: nxx_in = mul_p;
                        3'd2: nxy_in = mul_p;
                        3'd3: nyy_in = mul_p;
                        default: nhh_in = mul_p;
                     endcase
                  end
               endcase
               if ((phase_ff == PH_SUM && op_ff == 3'd3) ||
                   (phase_ff == PH_DEV && op_ff == 3'd7)) begin
                  if (idx_ff + CW'(1) == cnt_ff) begin
                     if (phase_ff == PH_SUM) begin
                        if (wsum_ff == '0) begin
                           state_in = ST_OUT;
                        end else begin
                           dop_in   = 3'd0;
                           state_in = ST_DIV;
                        end
                     end else if (nz_ff != 2'd2) begin
                        state_in = ST_OUT;
                     end else begin
                        phase_in = PH_DEN;
                        op_in    = '0;
                        state_in = ST_MUL;
                     end
                  end else begin
                     idx_in   = idx_ff + CW'(1);
                     state_in = ST_READ;
                  end
               end else if (phase_ff == PH_DEN && op_ff == 3'd4) begin
                  dop_in   = 3'd3;
                  state_in = ST_DIV;
               end else begin
                  op_in    = op_ff + 3'd1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         // Store the rounded quotient, saturated where needed
         ST_DIV_WAIT: begin
            if (div_done) begin
               case (dop_ff)
                  3'd0: res_in.mean_x = mean_val;
                  3'd1: res_in.mean_y = mean_val;
                  3'd2: res_in.mean_heading = mean_val;
                  3'd3: res_in.cov_xx = cov_u;
                  3'd4: res_in.cov_xy = axy_ff[ACC_W-1] ? COV_W'(-cov_s_mag) : cov_s_mag;
                  3'd5: res_in.cov_yy = cov_u;
                  default: res_in.cov_hh = cov_u;
               endcase
               if (dop_ff == 3'd2) begin
                  phase_in = PH_DEV;
                  idx_in   = '0;
                  state_in = ST_READ;
               end else if (dop_ff == 3'd6) begin
                  state_in = ST_OUT;
               end else begin
                  dop_in   = dop_ff + 3'd1;
                  state_in = ST_DIV;
               end
            end
         end
         // Hold the result until taken, then empty the set
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cnt_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      op_ff    <= op_in;
      dop_ff   <= dop_in;
      idx_ff   <= idx_in;
      nz_ff    <= nz_in;
      wsum_ff  <= wsum_in;
      s2_ff    <= s2_in;
      sumx_ff  <= sumx_in;
      sumy_ff  <= sumy_in;
      sumh_ff  <= sumh_in;
      axx_ff   <= axx_in;
      axy_ff   <= axy_in;
      ayy_ff   <= ayy_in;
      ahh_ff   <= ahh_in;
      prod_ff  <= prod_in;
      sgn_ff   <= sgn_in;
      den_ff   <= den_in;
      nxx_ff   <= nxx_in;
      nxy_ff   <= nxy_in;
      nyy_ff   <= nyy_in;
      nhh_ff   <= nhh_in;
      res_ff   <= res_in;
   end

   // Status by priority: zero weight, single sample, overflow
   always_comb begin
      rsp_data = res_ff;
      if (wsum_ff == '0) begin
         rsp_data.status = STATUS_ZERO_W;
      end else if (nz_ff != 2'd2) begin
         rsp_data.status = STATUS_SINGLE;
      end else if (ovf_ff) begin
         rsp_data.status = STATUS_OVERFLOW;
      end else begin
         rsp_data.status = STATUS_OK;
      end
   end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import wpmc_pkg::*;

   typedef struct {
      req_type item;
      bit      fixed;
      rsp_type answer;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Set-in-progress state of the predictor
   sample_type kept_samples[$];
   longint     weight_total;
   longint     weight_sq_total;
   longint     wx_total;
   longint     wy_total;
   longint     wh_total;
   bit         dropped_any;

   rsp_type    pending_results[$];
   bit         override_flags[$];
   rsp_type    override_values[$];
   int         error_count;
   int         send_idle_pct;
   int         recv_idle_pct;
   int         hold_left;
   bit         hold_trigger;
   bit         hold_done;

   weighted_pose_mean_covariance_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic void clear_set_state();
      kept_samples.delete();
      weight_total = 0;
      weight_sq_total = 0;
      wx_total = 0;
      wy_total = 0;
      wh_total = 0;
      dropped_any = 0;
   endfunction

   // Rounded division, ties up, clamped to lim
   function automatic logic [COV_W-1:0] round_div(logic [127:0] n, logic [127:0] d,
                                                  logic [COV_W-1:0] lim);
      logic [127:0] q;
      q = (2 * n + d) / (2 * d);
      return (q > lim) ? lim : q[COV_W-1:0];
   endfunction

   // Weighted mean, rounded to nearest with ties away from zero
   function automatic logic [POSE_W-1:0] mean_calc(longint s, longint w);
      longint m;
      longint q;
      logic [63:0] r;
      m = (s < 0) ? -s : s;
      q = (2 * m + w) / (2 * w);
      r = (s < 0) ? -q : q;
      return r[POSE_W-1:0];
   endfunction

   function automatic rsp_type close_pose_set();
      rsp_type            r;
      logic signed [127:0] axx, axy, ayy, ahh, wv, pv, mag;
      logic [127:0]        wbig, den;
      longint              smx, smy, smh, dx, dy, dh;
      int                  nonzero;
      logic [COV_W-1:0]    q;
      r = '0;
      axx = 0; axy = 0; ayy = 0; ahh = 0;
      nonzero = 0;
      if (weight_total == 0) begin
         r.status = STATUS_ZERO_W;
         return r;
      end
      r.mean_x = mean_calc(wx_total, weight_total);
      r.mean_y = mean_calc(wy_total, weight_total);
      r.mean_heading = mean_calc(wh_total, weight_total);
      smx = longint'(r.mean_x);
      smy = longint'(r.mean_y);
      smh = longint'(r.mean_heading);
      foreach (kept_samples[i]) begin
         wv = kept_samples[i].sample_weight;
         dx = longint'(kept_samples[i].pose_x) - smx;
         dy = longint'(kept_samples[i].pose_y) - smy;
         dh = longint'(kept_samples[i].pose_heading) - smh;
         if (wv != 0) nonzero++;
         pv = dx * dx; axx = axx + wv * pv;
         pv = dx * dy; axy = axy + wv * pv;
         pv = dy * dy; ayy = ayy + wv * pv;
         pv = dh * dh; ahh = ahh + wv * pv;
      end
      if (nonzero < 2) begin
         r.status = STATUS_SINGLE;
         return r;
      end
      wbig = weight_total;
      den = wbig * wbig - weight_sq_total;
      r.cov_xx = round_div(axx * wbig, den, COV_MAX_U);
      r.cov_yy = round_div(ayy * wbig, den, COV_MAX_U);
      r.cov_hh = round_div(ahh * wbig, den, COV_MAX_U);
      mag = (axy < 0) ? -axy : axy;
      q = round_div(mag * wbig, den, (axy < 0) ? COV_MAX_N : COV_MAX_P);
      r.cov_xy = (axy < 0) ? -q : q;
      r.status = dropped_any ? STATUS_OVERFLOW : STATUS_OK;
      return r;
   endfunction

   // Collect one accepted sample, close the set on the last one
   function automatic void absorb_sample(req_type it);
      sample_type s;
      rsp_type    r;
      longint     w;
      if (kept_samples.size() < DEF_MAX_SAMPLES) begin
         s.pose_x = it.pose_x;
         s.pose_y = it.pose_y;
         s.pose_heading = it.pose_heading;
         s.sample_weight = it.sample_weight;
         kept_samples.insert(kept_samples.size(), s);
         w = it.sample_weight;
         weight_total += w;
         weight_sq_total += w * w;
         wx_total += w * longint'(it.pose_x);
         wy_total += w * longint'(it.pose_y);
         wh_total += w * longint'(it.pose_heading);
      end else begin
         dropped_any = 1;
      end
      if (!it.last_sample) return;
      r = close_pose_set();
      if (override_flags.pop_front()) r = override_values.pop_front();
      else void'(override_values.pop_front());
      pending_results.insert(pending_results.size(), r);
      clear_set_state();
   endfunction

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected result transaction", got.status, 0);
         return;
      end
      want = pending_results.pop_front();
      if (got.mean_x !== want.mean_x) report_mismatch("mean_x", got.mean_x, want.mean_x);
      if (got.mean_y !== want.mean_y) report_mismatch("mean_y", got.mean_y, want.mean_y);
      if (got.mean_heading !== want.mean_heading)
         report_mismatch("mean_heading", got.mean_heading, want.mean_heading);
      if (got.cov_xx !== want.cov_xx) report_mismatch("cov_xx", got.cov_xx, want.cov_xx);
      if (got.cov_xy !== want.cov_xy) report_mismatch("cov_xy", got.cov_xy, want.cov_xy);
      if (got.cov_yy !== want.cov_yy) report_mismatch("cov_yy", got.cov_yy, want.cov_yy);
      if (got.cov_hh !== want.cov_hh) report_mismatch("cov_hh", got.cov_hh, want.cov_hh);
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
   endtask

   // Monitor both channels at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) absorb_sample(req_data);
         if (rsp_valid && rsp_ready) check_result(rsp_data);
      end
   end

   // Result receiver: random stalls plus one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_trigger && !hold_done) begin
            hold_left = 4000;
            hold_done = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_sample(req_type it, bit fixed, rsp_type answer);
      if (it.last_sample) begin
         override_flags.insert(override_flags.size(), fixed);
         override_values.insert(override_values.size(), answer);
      end
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
   endtask

   // Let the monitor see the last accepted sample before waiting
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [POSE_W-1:0] rand_coord();
      case ($urandom_range(7))
         0: return {1'b1, {(POSE_W-1){1'b0}}};
         1: return {1'b0, {(POSE_W-1){1'b1}}};
         2: return POSE_W'($urandom_range(8191) - 4096);
         default: return POSE_W'($urandom);
      endcase
   endfunction

   function automatic logic [POSE_W-1:0] rand_weight();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return POSE_W'($urandom_range(1, 255));
         default: return POSE_W'($urandom);
      endcase
   endfunction

   task automatic send_random_set(int count);
      req_type it;
      rsp_type none;
      none = '0;
      for (int i = 0; i < count; i++) begin
         it.pose_x = rand_coord();
         it.pose_y = rand_coord();
         it.pose_heading = rand_coord();
         it.sample_weight = rand_weight();
         it.last_sample = (i == count - 1);
         send_sample(it, 1'b0, none);
      end
   endtask

   task automatic run_random_phase(int item_goal);
      int sent;
      int n;
      sent = 0;
      while (sent < item_goal) begin
         n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
         send_random_set(n);
         sent += n;
      end
   endtask

   localparam logic [POSE_W-1:0] P_MAX = {1'b0, {(POSE_W-1){1'b1}}};
   localparam logic [POSE_W-1:0] P_MIN = {1'b1, {(POSE_W-1){1'b0}}};
   localparam logic [POSE_W-1:0] W_MAX = '1;

   // Directed stimulus; fixed answers only where obvious
   stim_row_type stim_table[] = '{
      '{'{P_MAX, P_MIN, 24'd5, 24'd0, 1'b1}, 1'b1, '{0, 0, 0, 0, 0, 0, 0, STATUS_ZERO_W}},
      '{'{P_MAX, P_MIN, P_MAX, W_MAX, 1'b1}, 1'b1,
        '{P_MAX, P_MIN, P_MAX, 0, 0, 0, 0, STATUS_SINGLE}},
      '{'{24'd7, 24'd9, 24'd3, 24'd0, 1'b0}, 1'b0, '0},
      '{'{24'd1, 24'd2, P_MIN, 24'd42, 1'b0}, 1'b0, '0},
      '{'{P_MIN, P_MAX, 24'd11, 24'd0, 1'b1}, 1'b1,
        '{24'd1, 24'd2, P_MIN, 0, 0, 0, 0, STATUS_SINGLE}},
      '{'{P_MIN, P_MAX, P_MIN, W_MAX, 1'b0}, 1'b0, '0},
      '{'{P_MAX, P_MIN, P_MAX, W_MAX, 1'b1}, 1'b0, '0},
      '{'{P_MIN, P_MIN, P_MIN, W_MAX, 1'b0}, 1'b0, '0},
      '{'{P_MAX, P_MAX, P_MAX, 24'd1, 1'b1}, 1'b0, '0},
      '{'{24'd0, 24'd0, 24'd0, 24'd0, 1'b0}, 1'b0, '0},
      '{'{24'd0, 24'd0, 24'd0, 24'd0, 1'b1}, 1'b1, '{0, 0, 0, 0, 0, 0, 0, STATUS_ZERO_W}},
      '{'{24'd4096, -24'sd4096, 24'd1000, 24'd3, 1'b0}, 1'b0, '0},
      '{'{-24'sd4096, 24'd4096, -24'sd1000, 24'd1, 1'b0}, 1'b0, '0},
      '{'{24'd8192, 24'd8192, 24'd0, 24'd2, 1'b1}, 1'b0, '0},
      '{'{24'd100, 24'd200, 24'd300, 24'd1, 1'b0}, 1'b0, '0},
      '{'{24'd101, 24'd199, 24'd301, 24'd1, 1'b1}, 1'b0, '0}
   };

   initial begin
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      reset = 1'b1;
      error_count = 0;
      hold_left = 0;
      hold_trigger = 0;
      hold_done = 0;
      send_idle_pct = 37;
      recv_idle_pct = 60;
      clear_set_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows
      foreach (stim_table[i]) send_sample(stim_table[i].item, stim_table[i].fixed,
                                          stim_table[i].answer);
      drain_results();

      // Long receiver hold while samples keep coming
      hold_trigger = 1;
      run_random_phase(280);
      drain_results();

      send_idle_pct = 60;
      recv_idle_pct = 37;
      run_random_phase(280);
      drain_results();

      // Overflow: the last sample falls past the store
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random_set(DEF_MAX_SAMPLES + 1);
      drain_results();
      run_random_phase(260);
      drain_results();

      repeat (200) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("missing result transactions", pending_results.size(), 0);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
